>>> sv/acu_pkg.sv
`default_nettype none
package acu_pkg;

    localparam int COUNT_WRAP_DEF   = 10000;
    localparam int CORDIC_STEPS_DEF = 16;

    // digit pairs of the 46-bit radicand
    localparam int SQRT_STEPS = 23;

    localparam int RAD_W  = 46;
    localparam int REM_W  = 26;
    localparam int ROOT_W = 23;
    localparam int VEC_W  = 26;
    localparam int ANG_W  = 28;

    localparam logic signed [15:0] ONE_Q14     = 16'sd16384;
    localparam logic [14:0]        PI_Q13      = 15'd25736;
    localparam logic [28:0]        ONE_SQ_Q28  = 29'h1000_0000;
    localparam logic [ANG_W-1:0]   HALF_PI_Q24 = 28'd26353589;
    localparam logic [ANG_W-1:0]   ROUND_Q24   = 28'd1024;

    typedef struct packed {
        logic              enable;
        logic signed [15:0] cosine_in;
    } t_in_word;

    typedef struct packed {
        logic [14:0] angle_out;
        logic        valid_out;
        logic [13:0] scan_count;
    } t_out_word;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sqrt;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ANG_W-1:0] z;
    } t_vec;

    // atan(2^-i) in Q.24, zero past the end of the table
    function automatic logic [ANG_W-1:0] atan_q24(input int i);
        logic [ANG_W-1:0] a;
        unique case (i)
            0:  a = 28'd13176795;
            1:  a = 28'd7778716;
            2:  a = 28'd4110060;
            3:  a = 28'd2086331;
            4:  a = 28'd1047214;
            5:  a = 28'd524117;
            6:  a = 28'd262123;
            7:  a = 28'd131069;
            8:  a = 28'd65536;
            9:  a = 28'd32768;
            10: a = 28'd16384;
            11: a = 28'd8192;
            12: a = 28'd4096;
            13: a = 28'd2048;
            14: a = 28'd1024;
            15: a = 28'd512;
            16: a = 28'd256;
            17: a = 28'd128;
            18: a = 28'd64;
            19: a = 28'd32;
            20: a = 28'd16;
            21: a = 28'd8;
            22: a = 28'd4;
            23: a = 28'd2;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

>>> sv/acu_stream_if.sv
`default_nettype none
interface acu_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/acu_sqrt_cell.sv
`default_nettype none
module acu_sqrt_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  acu_pkg::t_sqrt     i_data,
    output logic               o_valid,
    output acu_pkg::t_sqrt     o_data
);

    logic                       r_valid;
    acu_pkg::t_sqrt             r_data;
    acu_pkg::t_sqrt             n_data;
    logic [acu_pkg::REM_W-1:0]  rem_sh;
    logic [acu_pkg::REM_W-1:0]  trial;

    always_comb begin
        // bring down the next digit pair
        rem_sh = {i_data.rem[acu_pkg::REM_W-3:0], i_data.rad[acu_pkg::RAD_W-1 -: 2]};
        trial  = {1'b0, i_data.root, 2'b01};
        n_data.rad = {i_data.rad[acu_pkg::RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            n_data.rem  = rem_sh - trial;
            n_data.root = {i_data.root[acu_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            n_data.rem  = rem_sh;
            n_data.root = {i_data.root[acu_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

>>> sv/acu_cordic_cell.sv
`default_nettype none
module acu_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  acu_pkg::t_vec      i_vec,
    output logic               o_valid,
    output acu_pkg::t_vec      o_vec
);

    logic                             r_valid;
    acu_pkg::t_vec                    r_vec;
    acu_pkg::t_vec                    n_vec;
    logic signed [acu_pkg::VEC_W-1:0] x_in;
    logic signed [acu_pkg::VEC_W-1:0] y_in;
    logic signed [acu_pkg::VEC_W-1:0] dx;
    logic signed [acu_pkg::VEC_W-1:0] dy;
    logic signed [acu_pkg::ANG_W-1:0] a;

    always_comb begin
        x_in = i_vec.x;
        y_in = i_vec.y;
        dx   = y_in >>> STEP;
        dy   = x_in >>> STEP;
        a    = $signed(acu_pkg::atan_q24(STEP));
        if (!y_in[acu_pkg::VEC_W-1]) begin
            n_vec.x = x_in + dx;
            n_vec.y = y_in - dy;
            n_vec.z = i_vec.z + a;
        end else begin
            n_vec.x = x_in - dx;
            n_vec.y = y_in + dy;
            n_vec.z = i_vec.z - a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_vec <= n_vec;
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;

endmodule
`default_nettype wire

>>> sv/arccos_clamped_unit.sv
`default_nettype none
// arccos_clamped_unit: clamped arc cosine of a Q2.14 value, result in Q2.13 radians.
// i_in is a valid/ready sink of t_in_word (enable, cosine_in); o_out is a
// valid/ready source of t_out_word (angle_out, valid_out, scan_count).
// One word is worked on at a time. After acceptance the word squares the input
// into a register, forms the radicand in a register, runs through a chain of 23
// square root cells (one result bit each), then through CORDIC_STEPS vectoring
// cells, then a rounding and clamp stage, and then moves into the output register
// towards o_out. i_in.ready drops on acceptance and rises again as the result
// moves into the output register, so a new word is taken only after the last
// one has left the chain end.
// The output register is separate from the chain end, so a new word is taken
// while the previous result still waits on a stalled receiver; the chain end
// then holds its result until the output register frees.
// Reset (synchronous, active low) empties the chain and the output, and sets
// the held angle and the scan counter to zero.
module arccos_clamped_unit #(
    parameter int COUNT_WRAP   = acu_pkg::COUNT_WRAP_DEF,
    parameter int CORDIC_STEPS = acu_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    acu_stream_if.sink   i_in,
    acu_stream_if.source o_out
);

    localparam int NS = acu_pkg::SQRT_STEPS;

    acu_pkg::t_in_word  in_word;
    logic               accept;

    logic               r_busy;
    logic               r_go;
    logic               r_prep_v;
    logic               r_fin_v;
    logic               r_out_v;
    logic signed [15:0] r_c;
    logic               r_en;
    logic               r_over;
    logic               r_under;
    logic [30:0]        r_sq;
    logic [acu_pkg::RAD_W-1:0] r_rad;
    logic [14:0]        r_held;
    logic [13:0]        r_cnt;
    acu_pkg::t_out_word r_fin;
    acu_pkg::t_out_word r_out;

    logic signed [31:0] sq_full;
    logic [28:0]        rem29;
    logic [14:0]        cnt_inc;
    logic [13:0]        n_cnt;
    logic [14:0]        n_held;
    acu_pkg::t_out_word n_fin;
    logic               move;

    acu_pkg::t_sqrt     sq_data [0:NS];
    logic               sq_v    [0:NS];
    acu_pkg::t_vec      cd_vec  [0:CORDIC_STEPS];
    logic               cd_v    [0:CORDIC_STEPS];

    logic signed [acu_pkg::VEC_W-1:0] x0;
    logic signed [acu_pkg::VEC_W-1:0] y0;
    logic signed [acu_pkg::ANG_W-1:0] zr;
    logic signed [16:0]               q;
    logic [14:0]                      q_clamp;

    assign in_word    = i_in.data;
    assign i_in.ready = !r_busy;
    assign accept     = i_in.valid && !r_busy;
    assign move       = r_fin_v && (!r_out_v || o_out.ready);

    assign o_out.valid = r_out_v;
    assign o_out.data  = r_out;

    always_comb begin
        sq_full = in_word.cosine_in * in_word.cosine_in;
        rem29   = acu_pkg::ONE_SQ_Q28 - r_sq[28:0];
        cnt_inc = {1'b0, r_cnt} + 15'd1;
        if (cnt_inc >= 15'(COUNT_WRAP)) begin
            n_cnt = '0;
        end else begin
            n_cnt = cnt_inc[13:0];
        end
    end

    // square root chain
    assign sq_v[0]         = r_prep_v;
    assign sq_data[0].rad  = r_rad;
    assign sq_data[0].rem  = '0;
    assign sq_data[0].root = '0;

    for (genvar j = 0; j < NS; j++) begin : g_sqrt
        acu_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_v[j]),
            .i_data  (sq_data[j]),
            .o_valid (sq_v[j+1]),
            .o_data  (sq_data[j+1])
        );
    end

    // negative cosine starts from the vector turned by -pi/2
    always_comb begin
        x0 = {{2{r_c[15]}}, r_c, 8'b0};
        y0 = {3'b0, sq_data[NS].root};
        if (r_c[15]) begin
            cd_vec[0].x = y0;
            cd_vec[0].y = -x0;
            cd_vec[0].z = $signed(acu_pkg::HALF_PI_Q24);
        end else begin
            cd_vec[0].x = x0;
            cd_vec[0].y = y0;
            cd_vec[0].z = '0;
        end
    end
    assign cd_v[0] = sq_v[NS];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        acu_cordic_cell #(
            .STEP (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (cd_v[i]),
            .i_vec   (cd_vec[i]),
            .o_valid (cd_v[i+1]),
            .o_vec   (cd_vec[i+1])
        );
    end

    always_comb begin
        zr = cd_vec[CORDIC_STEPS].z + $signed(acu_pkg::ROUND_Q24);
        q  = zr[acu_pkg::ANG_W-1:11];
        if (q[16]) begin
            q_clamp = '0;
        end else if (q[15:0] > {1'b0, acu_pkg::PI_Q13}) begin
            q_clamp = acu_pkg::PI_Q13;
        end else begin
            q_clamp = q[14:0];
        end

        n_held          = r_held;
        n_fin.valid_out = 1'b0;
        if (r_en) begin
            priority if (r_over) begin
                n_held = '0;
            end else if (r_under) begin
                n_held = acu_pkg::PI_Q13;
            end else begin
                n_held          = q_clamp;
                n_fin.valid_out = 1'b1;
            end
        end
        n_fin.angle_out  = n_held;
        n_fin.scan_count = r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_go     <= 1'b0;
            r_prep_v <= 1'b0;
            r_fin_v  <= 1'b0;
            r_out_v  <= 1'b0;
            r_held   <= '0;
            r_cnt    <= '0;
        end else begin
            r_go     <= accept;
            r_prep_v <= r_go;
            if (accept) begin
                r_busy <= 1'b1;
                r_cnt  <= n_cnt;
            end
            if (cd_v[CORDIC_STEPS]) begin
                r_fin_v <= 1'b1;
                r_held  <= n_held;
            end
            if (move) begin
                r_fin_v <= 1'b0;
                r_out_v <= 1'b1;
                r_busy  <= 1'b0;
            end else if (r_out_v && o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
        if (accept) begin
            r_c     <= in_word.cosine_in;
            r_en    <= in_word.enable;
            r_over  <= in_word.cosine_in > acu_pkg::ONE_Q14;
            r_under <= in_word.cosine_in < -acu_pkg::ONE_Q14;
            r_sq    <= sq_full[30:0];
        end
        r_rad <= {1'b0, rem29, 16'b0};
        if (cd_v[CORDIC_STEPS]) begin
            r_fin <= n_fin;
        end
        if (move) begin
            r_out <= r_fin;
        end
    end

endmodule
`default_nettype wire
